// ===== hdl/three_channel_window_monitor_top_assert.svh =====
// Assertion macros shared by the window monitor.
`ifndef THREE_CHANNEL_WINDOW_MONITOR_TOP_ASSERT_SVH
`define THREE_CHANNEL_WINDOW_MONITOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("window monitor check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TCWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("window monitor check failed one cycle later");

`endif

// ===== hdl/tcwm_pkg.sv =====
package tcwm_pkg;

	localparam int NumChannels = 3;
	localparam int NumRegs     = 7;
	localparam int ByteW       = 8;
	localparam int LampW       = 2 * NumChannels;
	localparam int RegIdxW     = $clog2(NumRegs);
	localparam int ChanPtrW    = 2;

	// Register indexes on the configuration port.
	localparam logic [RegIdxW-1:0] REG_LOW_A   = 3'd0;
	localparam logic [RegIdxW-1:0] REG_HIGH_A  = 3'd1;
	localparam logic [RegIdxW-1:0] REG_LOW_B   = 3'd2;
	localparam logic [RegIdxW-1:0] REG_HIGH_B  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_LOW_C   = 3'd4;
	localparam logic [RegIdxW-1:0] REG_HIGH_C  = 3'd5;
	localparam logic [RegIdxW-1:0] REG_RELOAD  = 3'd6;

	// Input beat kinds.
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	localparam logic [ByteW-1:0] CountdownReset = 8'd10;

	localparam logic [ByteW-1:0] RegResetVals [NumRegs] = '{
		8'h1F, 8'hB0, 8'h67, 8'hB0, 8'h6B, 8'hB0, 8'd10
	};

	// One report run handed from the evaluation logic to the output serializer.
	typedef struct packed {
		logic                                valid;
		logic [NumChannels-1:0][ByteW-1:0]   values;
		logic [LampW-1:0]                    lamps;
	} tcwm_report_t;

	// Window check of one channel. Returns {high lamp, low lamp}.
	// A value equal to either limit keeps the current lamps, unless it is also below the low or above the high limit.
	function automatic logic [1:0] judge_window(
		input logic [ByteW-1:0] value,
		input logic [ByteW-1:0] low_lim,
		input logic [ByteW-1:0] high_lim,
		input logic [1:0]       cur
	);
		logic [1:0] res;
		if (value < low_lim) begin
			res = 2'b01;
		end else if (value > low_lim && value < high_lim) begin
			res = 2'b00;
		end else if (value > high_lim) begin
			res = 2'b10;
		end else begin
			res = cur;
		end
		return res;
	endfunction

endpackage

// ===== hdl/tcwm_in_if.sv =====
interface tcwm_in_if;
	import tcwm_pkg::*;

	logic             valid;
	logic             ready;
	logic             mode;
	logic [ByteW-1:0] sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink (input valid, input mode, input sample, output ready);
endinterface

// ===== hdl/tcwm_out_if.sv =====
interface tcwm_out_if;
	import tcwm_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] tx_byte;
	logic [LampW-1:0] lamps;
	logic             last;

	modport source (output valid, output tx_byte, output lamps, output last, input ready);
	modport sink (input valid, input tx_byte, input lamps, input last, output ready);
endinterface

// ===== hdl/tcwm_cfg_if.sv =====
interface tcwm_cfg_if;
	import tcwm_pkg::*;

	logic               valid;
	logic               ready;
	logic [RegIdxW-1:0] index;
	logic [ByteW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/three_channel_window_monitor_top.sv =====
// Sample beats and ticks that do not expire update state on acceptance and give no result.
// An expiring tick gives its first result beat the cycle after acceptance, in a run of three beats.
// Throughput: one input beat per cycle while no report run is in flight; a report run takes
// three output beats, and input is held off until the third beat is taken.
// Reset: limits and reload to defaults, countdown to ten, values, pointer and lamps cleared.
`include "three_channel_window_monitor_top_assert.svh"

module three_channel_window_monitor_top (
	input  logic      clk,
	input  logic      arst_n,
	tcwm_in_if.sink   samples,
	tcwm_out_if.source results,
	tcwm_cfg_if.sink  cfg
);
	import tcwm_pkg::*;

	logic [ByteW-1:0]                  regs_q [NumRegs];
	logic [NumChannels-1:0][ByteW-1:0] values_q;
	logic [ChanPtrW-1:0]               ptr_q;
	logic [ByteW-1:0]                  countdown_q;
	logic [LampW-1:0]                  lamps_q;
	logic [LampW-1:0]                  lamps_next;
	logic                              accept;
	logic                              expire;
	logic                              report_free;
	tcwm_report_t                      report;

	assign cfg.ready     = 1'b1;
	assign samples.ready = report_free;
	assign accept        = samples.valid && samples.ready;
	assign expire        = accept && (samples.mode == MODE_TICK) && (countdown_q == '0);

	// Configuration registers; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) begin
				regs_q[i] <= RegResetVals[i];
			end
		end else if (cfg.valid && cfg.ready && (cfg.index <= REG_RELOAD)) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	// Window checks of all channels against the current stored values.
	always_comb begin
		lamps_next = lamps_q;
		for (int k = 0; k < NumChannels; k++) begin
			lamps_next[2*k +: 2] = judge_window(values_q[k], regs_q[2*k], regs_q[2*k+1],
				lamps_q[2*k +: 2]);
		end
	end

	// Sample storage: the pointer walks four slots, the last one drops the byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			values_q <= '0;
		end else if (accept && (samples.mode == MODE_SAMPLE)) begin
			for (int k = 0; k < NumChannels; k++) begin
				if (ptr_q == ChanPtrW'(k)) begin
					values_q[k] <= samples.sample;
				end
			end
			ptr_q <= ptr_q + 1'b1;
		end
	end

	// Tick countdown and lamp update on expiry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= CountdownReset;
			lamps_q     <= '0;
		end else if (expire) begin
			countdown_q <= regs_q[REG_RELOAD];
			lamps_q     <= lamps_next;
		end else if (accept && (samples.mode == MODE_TICK)) begin
			countdown_q <= countdown_q - 1'b1;
		end
	end

	// Report run to the serializer.
	always_comb begin
		report.valid  = expire;
		report.values = values_q;
		report.lamps  = lamps_next;
	end

	tcwm_report u_report (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (report),
		.free    (report_free),
		.results (results)
	);

	// A run is never loaded over one still in flight.
	`TCWM_ASSERT_SAME(a_load_when_free, clk, arst_n, report.valid, report_free)
	// An expiring tick shows its first beat in the next cycle.
	`TCWM_ASSERT_NEXT(a_expire_reports, clk, arst_n, expire, results.valid && !results.last)
	// A run continues after any beat but the third.
	`TCWM_ASSERT_NEXT(a_run_continues, clk, arst_n,
		results.valid && results.ready && !results.last, results.valid)
	// Input is only taken during a run while its third beat leaves.
	`TCWM_ASSERT_SAME(a_input_hold, clk, arst_n, samples.ready && results.valid,
		results.last && results.ready)

endmodule

// ===== hdl/tcwm_report.sv =====
module tcwm_report (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcwm_pkg::tcwm_report_t load,
	output logic                   free,
	tcwm_out_if.source             results
);
	import tcwm_pkg::*;

	logic [NumChannels-1:0][ByteW-1:0] values_q;
	logic [LampW-1:0]                  lamps_q;
	logic [ChanPtrW-1:0]               idx_q;
	logic                              busy_q;
	logic                              pop;
	logic                              last_beat;

	// Beat bookkeeping.
	assign last_beat = (idx_q == ChanPtrW'(NumChannels - 1));
	assign pop       = busy_q && results.ready;
	assign free      = !busy_q || (pop && last_beat);

	// Output beat, one stored channel value per beat.
	assign results.valid   = busy_q;
	assign results.tx_byte = values_q[idx_q];
	assign results.lamps   = lamps_q;
	assign results.last    = last_beat;

	// Run control: a new run is loaded only when the buffer is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load.valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (pop) begin
			if (last_beat) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Report payload.
	always_ff @(posedge clk) begin
		if (load.valid) begin
			values_q <= load.values;
			lamps_q  <= load.lamps;
		end
	end

endmodule

// ===== dv/three_channel_window_monitor_top_tb.sv =====
`timescale 1ns / 100ps

module three_channel_window_monitor_top_tb;
	import tcwm_pkg::*;

	localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;
	localparam logic [RegIdxW-1:0] LOW_REG_OF [NumChannels] = '{REG_LOW_A, REG_LOW_B, REG_LOW_C};
	localparam logic [RegIdxW-1:0] HIGH_REG_OF [NumChannels] =
		'{REG_HIGH_A, REG_HIGH_B, REG_HIGH_C};

	typedef struct {
		logic             mode;
		logic [ByteW-1:0] sample;
		logic             hold;
	} in_beat_t;

	typedef struct {
		logic [ByteW-1:0] tx_byte;
		logic [LampW-1:0] lamps;
		logic             last;
	} report_beat_t;

	logic clk;
	logic arst_n;

	tcwm_in_if  in_bus ();
	tcwm_out_if out_bus ();
	tcwm_cfg_if cfg_bus ();

	three_channel_window_monitor_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_bus),
		.results (out_bus),
		.cfg     (cfg_bus)
	);

	// Beats waiting to be sent, and report beats the block still owes.
	in_beat_t     input_beats [$];
	report_beat_t report_beats [$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;

	// Predicted state of the monitor.
	logic [ByteW-1:0]    model_regs [NumRegs];
	logic [ByteW-1:0]    model_vals [NumChannels];
	logic [ChanPtrW-1:0] model_ptr;
	logic [ByteW-1:0]    model_countdown;
	logic [LampW-1:0]    model_lamps;

	// Channel pointer as seen by the stimulus generator, ahead of the model by the queued samples.
	logic [ChanPtrW-1:0] gen_ptr;

	// Apply one accepted input beat and queue any report beats it causes.
	task automatic predict_window_report(input in_beat_t b);
		logic [ByteW-1:0] v;
		logic [ByteW-1:0] lo;
		logic [ByteW-1:0] hi;
		report_beat_t     r;
		if (b.mode == MODE_SAMPLE) begin
			if (model_ptr < NumChannels) begin
				model_vals[model_ptr] = b.sample;
			end
			model_ptr = model_ptr + 1'b1;
		end else if (model_countdown != '0) begin
			model_countdown = model_countdown - 1'b1;
		end else begin
			model_countdown = model_regs[REG_RELOAD];
			for (int k = 0; k < NumChannels; k++) begin
				v  = model_vals[k];
				lo = model_regs[LOW_REG_OF[k]];
				hi = model_regs[HIGH_REG_OF[k]];
				// Lamp pair is {high, low}; a value on a limit keeps it unless also below low or above high.
				if (v < lo) begin
					model_lamps[2*k +: 2] = 2'b01;
				end else if (v > lo && v < hi) begin
					model_lamps[2*k +: 2] = 2'b00;
				end else if (v > hi) begin
					model_lamps[2*k +: 2] = 2'b10;
				end
			end
			for (int k = 0; k < NumChannels; k++) begin
				r.tx_byte = model_vals[k];
				r.lamps   = model_lamps;
				r.last    = (k == NumChannels - 1);
				report_beats.push_back(r);
			end
		end
	endtask

	// Input driver: holds a beat until it is taken, then offers the next one.
	always @(posedge clk) begin
		logic     send;
		in_beat_t head;
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
		end else begin
			if (in_bus.valid && in_bus.ready) begin
				predict_window_report(input_beats.pop_front());
			end
			if (!(in_bus.valid && !in_bus.ready)) begin
				send = 1'b0;
				if (input_beats.size() > 0) begin
					head = input_beats[0];
					send = ($urandom_range(99) >= send_idle_pct);
					// A held beat waits until every owed report beat has come out.
					if (head.hold && report_beats.size() != 0) begin
						send = 1'b0;
					end
				end
				in_bus.valid <= send;
				if (send) begin
					in_bus.mode   <= head.mode;
					in_bus.sample <= head.sample;
				end
			end
		end
	end

	// Result monitor: compares each taken beat with the oldest prediction.
	always @(posedge clk) begin
		report_beat_t want;
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				if (report_beats.size() == 0) begin
					$error("report beat with nothing expected: tx_byte %0h lamps %0h last %0b",
						out_bus.tx_byte, out_bus.lamps, out_bus.last);
					mismatch_count++;
				end else begin
					want = report_beats.pop_front();
					if (out_bus.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %0h, got %0h", want.tx_byte, out_bus.tx_byte);
						mismatch_count++;
					end
					if (out_bus.lamps !== want.lamps) begin
						$error("lamps: expected %0h, got %0h", want.lamps, out_bus.lamps);
						mismatch_count++;
					end
					if (out_bus.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, out_bus.last);
						mismatch_count++;
					end
				end
			end
			out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// Write one register; called at a clock edge, leaves valid high on return.
	task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [ByteW-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		if (idx < NumRegs) begin
			model_regs[idx] = value;
		end
	endtask

	task automatic set_limits(
		input logic [ByteW-1:0] low_a,
		input logic [ByteW-1:0] high_a,
		input logic [ByteW-1:0] low_b,
		input logic [ByteW-1:0] high_b,
		input logic [ByteW-1:0] low_c,
		input logic [ByteW-1:0] high_c,
		input logic [ByteW-1:0] reload
	);
		write_reg(REG_LOW_A, low_a);
		write_reg(REG_HIGH_A, high_a);
		write_reg(REG_LOW_B, low_b);
		write_reg(REG_HIGH_B, high_b);
		write_reg(REG_LOW_C, low_c);
		write_reg(REG_HIGH_C, high_c);
		write_reg(REG_RELOAD, reload);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic push_sample(input logic [ByteW-1:0] value);
		in_beat_t b;
		b.mode   = MODE_SAMPLE;
		b.sample = value;
		b.hold   = 1'b0;
		input_beats.push_back(b);
		gen_ptr = gen_ptr + 1'b1;
	endtask

	task automatic push_tick();
		in_beat_t b;
		b.mode   = MODE_TICK;
		b.sample = ByteW'($urandom_range(255));
		b.hold   = 1'b0;
		input_beats.push_back(b);
	endtask

	// Random beat; samples lean toward the limits of the channel they will land in.
	function automatic in_beat_t random_beat(input int tick_pct);
		in_beat_t         b;
		logic [ByteW-1:0] lo;
		logic [ByteW-1:0] hi;
		b.hold   = 1'b0;
		b.sample = ByteW'($urandom_range(255));
		if ($urandom_range(99) < tick_pct) begin
			b.mode = MODE_TICK;
		end else begin
			b.mode = MODE_SAMPLE;
			if (gen_ptr < NumChannels) begin
				lo = model_regs[LOW_REG_OF[gen_ptr]];
				hi = model_regs[HIGH_REG_OF[gen_ptr]];
				case ($urandom_range(9))
					0: b.sample = lo;
					1: b.sample = hi;
					2: b.sample = lo + 1'b1;
					3: b.sample = lo - 1'b1;
					4: b.sample = hi + 1'b1;
					5: b.sample = hi - 1'b1;
					default: ;
				endcase
			end
			gen_ptr = gen_ptr + 1'b1;
		end
		return b;
	endfunction

	// Wait until everything sent has been taken and every report beat has arrived.
	task automatic settle();
		do @(posedge clk); while (input_beats.size() != 0 || in_bus.valid ||
			report_beats.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input int count, input int tick_pct, input bit with_pause);
		in_beat_t b;
		for (int i = 0; i < count; i++) begin
			b = random_beat(tick_pct);
			if (with_pause && i == count / 2) begin
				b.hold = 1'b1;
			end
			input_beats.push_back(b);
		end
		settle();
	endtask

	// Main sequence.
	initial begin
		in_bus.valid   = 1'b0;
		in_bus.mode    = MODE_SAMPLE;
		in_bus.sample  = '0;
		cfg_bus.valid  = 1'b0;
		cfg_bus.index  = REG_LOW_A;
		cfg_bus.data   = '0;
		out_bus.ready  = 1'b0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		send_idle_pct  = 23;
		recv_idle_pct  = 71;
		gen_ptr        = '0;

		for (int i = 0; i < NumRegs; i++) begin
			model_regs[i] = RegResetVals[i];
		end
		for (int k = 0; k < NumChannels; k++) begin
			model_vals[k] = '0;
		end
		model_ptr       = '0;
		model_countdown = CountdownReset;
		model_lamps     = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Out-of-range index first, then a window set with the low limit above the high one.
		write_reg(REG_UNUSED, 8'h5A);
		set_limits(8'h40, 8'hC0, 8'h00, 8'hFF, 8'h90, 8'h50, 8'd0);

		// Directed: extremes, values on the limits, and the dropped fourth sample.
		push_sample(8'h00);
		push_sample(8'hFF);
		push_sample(8'h80);
		push_sample(8'hAA);
		// The countdown starts at ten, so the eleventh tick reports.
		repeat (11) push_tick();
		push_sample(8'h40);
		push_sample(8'h00);
		push_sample(8'h90);
		push_sample(8'h33);
		push_tick();
		push_sample(8'hE0);
		push_sample(8'h7F);
		push_sample(8'h50);
		push_sample(8'h00);
		push_tick();
		settle();

		// Random with the reload at zero, so every tick reports.
		run_random(55, 35, 1'b1);

		// Full-range window, inverted window, and a zero-width window.
		send_idle_pct = 71;
		recv_idle_pct = 23;
		set_limits(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h80, 8'd1);
		run_random(55, 40, 1'b1);

		// Longest reload: mostly ticks so the full countdown runs out once.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
			ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
			ByteW'($urandom_range(255)), ByteW'($urandom_range(255)), 8'd255);
		run_random(300, 93, 1'b0);

		set_limits(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
			ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
			ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
			ByteW'($urandom_range(6, 2)));
		run_random(45, 35, 1'b0);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
